// ===== src/wbps_pkg.sv =====
// ============================================================================
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scan unit:
// configuration register indexes, register widths and the config bundle.
// ============================================================================
package wbps_pkg;

    // bytes held by the pattern registers
    localparam int PATTERN_BYTES   = 32;
    localparam int PATTERN_WORDS   = 4;
    localparam int LEN_W           = 6;
    localparam int MASK_W          = 32;

    // default module parameters
    localparam int MAX_PATTERN_LEN_DEFAULT = 32;
    localparam int OFFSET_BITS_DEFAULT     = 32;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd5;

    // reset value of the length register
    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd1;

    // configuration bundle, word 0 holds pattern bytes 0 to 7
    typedef struct packed {
        logic [LEN_W-1:0]                          pattern_length;
        logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0]  pattern_words;
        logic [MASK_W-1:0]                         wildcard_mask;
    } wbps_cfg_t;

endpackage

// ===== src/wbps_cfg.sv =====
// ============================================================================
// wbps_cfg
// Configuration register file: pattern length, pattern bytes and wildcard
// mask, written through a plain write port.
// ============================================================================
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output wbps_cfg_t              cfg
);

    wbps_cfg_t cfg_reg;
    wbps_cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: cfg_next.pattern_length   = cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    cfg_next.pattern_words[0] = cfg_data;
                REG_PATTERN_SECOND: cfg_next.pattern_words[1] = cfg_data;
                REG_PATTERN_THIRD:  cfg_next.pattern_words[2] = cfg_data;
                REG_PATTERN_HIGH:   cfg_next.pattern_words[3] = cfg_data;
                REG_WILDCARD_MASK:  cfg_next.wildcard_mask    = cfg_data[MASK_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_length <= PATTERN_LENGTH_RESET;
            cfg_reg.pattern_words  <= '0;
            cfg_reg.wildcard_mask  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/wbps_window.sv =====
// ============================================================================
// wbps_window
// Sliding byte window, fill count and buffer offset. The shifted window and
// the saturated fill count are presented for the compare of the byte in flight.
// ============================================================================
module wbps_window
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEFAULT,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEFAULT,
    localparam int FILL_W         = $clog2(MAX_PATTERN_LEN + 1)
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [7:0]                       data_byte,
    input  logic                             last,
    output logic [MAX_PATTERN_LEN-1:0][7:0]  window_shifted,
    output logic [FILL_W-1:0]                fill_seen,
    output logic [OFFSET_BITS-1:0]           cur_offset
);

    logic [MAX_PATTERN_LEN-1:0][7:0] window_reg;
    logic [FILL_W-1:0]               fill_reg;
    logic [FILL_W-1:0]               fill_next;
    logic [OFFSET_BITS-1:0]          offset_reg;
    logic [OFFSET_BITS-1:0]          offset_next;

    // newest byte at position 0
    assign window_shifted = {window_reg[MAX_PATTERN_LEN-2:0], data_byte};

    // fill count including the byte in flight, saturating
    assign fill_seen = (fill_reg == FILL_W'(MAX_PATTERN_LEN)) ? fill_reg
                                                               : fill_reg + 1'b1;
    assign cur_offset = offset_reg;

    // end of buffer restarts fill and offset
    always_comb
    begin
        fill_next   = fill_reg;
        offset_next = offset_reg;
        if (advance)
        begin
            if (last)
            begin
                fill_next   = '0;
                offset_next = '0;
            end
            else
            begin
                fill_next   = fill_seen;
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            offset_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            offset_reg <= offset_next;
        end
    end

    // window bytes beyond the fill count are never compared
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_reg <= window_shifted;
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_PATTERN_LEN))
        else $error("window fill count above window depth");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> fill_reg == '0 && offset_reg == '0)
        else $error("end of buffer did not clear fill and offset");

    a_offset_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last |=> offset_reg == OFFSET_BITS'($past(offset_reg) + 1'b1))
        else $error("buffer offset did not advance by one");

endmodule

// ===== src/wbps_match.sv =====
// ============================================================================
// wbps_match
// Parallel compare of the window against the length-aligned pattern with
// wildcard positions, plus the start offset of a match.
// ============================================================================
module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEFAULT,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEFAULT,
    localparam int FILL_W         = $clog2(MAX_PATTERN_LEN + 1),
    localparam int EFF_MAX        = (MAX_PATTERN_LEN < PATTERN_BYTES) ? MAX_PATTERN_LEN
                                                                       : PATTERN_BYTES
)
(
    input  wbps_cfg_t                        cfg,
    input  logic [MAX_PATTERN_LEN-1:0][7:0]  window,
    input  logic [FILL_W-1:0]                fill_seen,
    input  logic [OFFSET_BITS-1:0]           cur_offset,
    output logic                             hit,
    output logic [OFFSET_BITS-1:0]           start_offset
);

    logic [LEN_W-1:0]                    len_eff;
    logic [PATTERN_BYTES-1:0][7:0]       pat_bytes;
    logic [MAX_PATTERN_LEN-1:0]          pos_ok;

    // clamp length to 1 .. EFF_MAX
    always_comb
    begin
        priority if (cfg.pattern_length == '0)
            len_eff = LEN_W'(1);
        else if (cfg.pattern_length > LEN_W'(EFF_MAX))
            len_eff = LEN_W'(EFF_MAX);
        else
            len_eff = cfg.pattern_length;
    end

    assign pat_bytes = cfg.pattern_words;

    // window position j faces pattern position len-1-j
    for (genvar j = 0; j < MAX_PATTERN_LEN; j++)
    begin : g_pos
        logic [LEN_W-1:0] idx;
        logic             in_use;
        logic             wild;

        assign idx    = len_eff - LEN_W'(1) - LEN_W'(j);
        assign in_use = LEN_W'(j) < len_eff;
        // position 0 is always compared exactly
        assign wild   = (idx != '0) && cfg.wildcard_mask[idx[4:0]];
        assign pos_ok[j] = !in_use || wild || (window[j] == pat_bytes[idx[4:0]]);
    end

    // no match until the buffer holds a full pattern
    assign hit = (&pos_ok) && (32'(fill_seen) >= 32'(len_eff));

    assign start_offset = cur_offset - OFFSET_BITS'(len_eff - LEN_W'(1));

endmodule

// ===== src/wildcard_byte_pattern_scan_unit.sv =====
// match_offset is registered in the result register when its byte leaves the input register.
// Throughput: one byte per cycle; the single window compare stage sets the rate.
// A stall on the result channel holds the compare stage and then the input.
// Reset (rst_n, async, active low) clears the pipeline, window fill and offset, and
// returns the registers to pattern_length 1 and all-zero pattern bytes and mask.
// ============================================================================
// wildcard_byte_pattern_scan_unit
// Wildcard byte pattern scanner: input register, window compare against the
// configured pattern, and a result register holding the match start offset.
// ============================================================================
module wildcard_byte_pattern_scan_unit
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEFAULT,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_buffer,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            match_offset
);

    localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);

    wbps_cfg_t                        cfg;
    logic [MAX_PATTERN_LEN-1:0][7:0]  window_shifted;
    logic [FILL_W-1:0]                fill_seen;
    logic [OFFSET_BITS-1:0]           cur_offset;
    logic                             hit;
    logic [OFFSET_BITS-1:0]           start_offset;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] match_offset_reg;
    logic        in_accept;
    logic        advance;

    wbps_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    wbps_window #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .OFFSET_BITS     (OFFSET_BITS)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .data_byte      (s1_byte_reg),
        .last           (s1_last_reg),
        .window_shifted (window_shifted),
        .fill_seen      (fill_seen),
        .cur_offset     (cur_offset)
    );

    wbps_match #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .OFFSET_BITS     (OFFSET_BITS)
    ) u_match (
        .cfg          (cfg),
        .window       (window_shifted),
        .fill_seen    (fill_seen),
        .cur_offset   (cur_offset),
        .hit          (hit),
        .start_offset (start_offset)
    );

    // handshake: compare stage moves when the result slot is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // input stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    // result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = hit;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= end_of_buffer;
        end
        if (advance && hit)
        begin
            match_offset_reg <= 32'(start_offset);
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_offset = match_offset_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty compare stage");

    a_result_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && hit))
        else $error("result appeared without a matching transaction");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !advance |=> !out_valid_reg)
        else $error("taken result was not released");

endmodule

// ===== bench/scan_match_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// scan_match_monitor
// Watches the byte and result channels of the pattern scan unit, keeps its
// own sliding window and register copy, predicts the start offset of every
// match and compares each reported offset in order of arrival.
// ============================================================================
module scan_match_monitor
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEFAULT,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_buffer,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [31:0]            match_offset,
    output int                     mismatch_count,
    output int                     offsets_pending
);

    wbps_cfg_t              shadow_cfg;
    logic [7:0]             recent_bytes [MAX_PATTERN_LEN];
    int                     bytes_held;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [31:0]            expected_offsets [$];

    // one line per mismatch
    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // empty window, offset back to the buffer start
    function automatic void clear_window();
        int k;
        for (k = 0; k < MAX_PATTERN_LEN; k++)
            recent_bytes[k] = 8'h00;
        bytes_held  = 0;
        next_offset = '0;
    endfunction

    // shift one byte in and decide whether a full match ends on it
    function automatic void scan_byte(input logic [7:0] value, input logic last,
                                      output bit found, output logic [31:0] start);
        int                     span;
        int                     k;
        logic [CFG_DATA_W-1:0]  word;
        logic [7:0]             want;
        logic [OFFSET_BITS-1:0] first;
        span = int'(shadow_cfg.pattern_length);
        if (span < 1)
            span = 1;
        if (span > MAX_PATTERN_LEN)
            span = MAX_PATTERN_LEN;
        if (span > PATTERN_BYTES)
            span = PATTERN_BYTES;
        for (k = MAX_PATTERN_LEN - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = value;
        if (bytes_held < MAX_PATTERN_LEN)
            bytes_held++;
        found = 1'b0;
        start = '0;
        // short buffer: not enough bytes yet for the whole pattern
        if (bytes_held >= span)
        begin
            found = 1'b1;
            for (k = 0; k < span; k++)
            begin
                word = shadow_cfg.pattern_words[k / 8];
                want = word[(k % 8) * 8 +: 8];
                // position 0 always compared exactly
                if ((k == 0 || !shadow_cfg.wildcard_mask[k]) &&
                    recent_bytes[span - 1 - k] != want)
                    found = 1'b0;
            end
            first = next_offset - OFFSET_BITS'(span - 1);
            start = 32'(first);
        end
        if (last)
            clear_window();
        else
            next_offset = next_offset + 1'b1;
    endfunction

    // sample both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : track
        bit          found;
        logic [31:0] start;
        logic [31:0] oldest;
        if (!rst_n)
        begin
            shadow_cfg.pattern_length = PATTERN_LENGTH_RESET;
            shadow_cfg.pattern_words  = '0;
            shadow_cfg.wildcard_mask  = '0;
            clear_window();
            expected_offsets.delete();
        end
        else
        begin
            // result transaction against the oldest expected offset
            if (out_valid && !out_stall)
            begin
                if (expected_offsets.size() == 0)
                    report_mismatch($sformatf("unexpected match_offset %0d", match_offset));
                else
                begin
                    oldest = expected_offsets.pop_front();
                    if (match_offset !== oldest)
                        report_mismatch($sformatf("match_offset %0d, expected %0d",
                                                  match_offset, oldest));
                end
            end
            // register writes, unknown indexes ignored
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: shadow_cfg.pattern_length   = cfg_data[LEN_W-1:0];
                    REG_PATTERN_LOW:    shadow_cfg.pattern_words[0] = cfg_data;
                    REG_PATTERN_SECOND: shadow_cfg.pattern_words[1] = cfg_data;
                    REG_PATTERN_THIRD:  shadow_cfg.pattern_words[2] = cfg_data;
                    REG_PATTERN_HIGH:   shadow_cfg.pattern_words[3] = cfg_data;
                    REG_WILDCARD_MASK:  shadow_cfg.wildcard_mask    = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            // byte transaction through the window model
            if (in_valid && !in_stall)
            begin
                scan_byte(data_byte, end_of_buffer, found, start);
                if (found)
                    expected_offsets = {expected_offsets, start};
            end
        end
        offsets_pending = expected_offsets.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus for the wildcard byte pattern scan unit: directed buffers for the
// length limits, wildcard handling and buffer boundaries, then random
// patterns with planted, damaged and cut-off occurrences under random idling
// on both channels. Checking is done by scan_match_monitor.
// ============================================================================
module testbench;
    import wbps_pkg::*;

    localparam int ITEM_TARGET   = 1400;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PERCENT  = 38;
    localparam int TIMEOUT_NS    = 5_000_000;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write_en  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [7:0]             data_byte     = 8'h00;
    logic                   end_of_buffer = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic [31:0]            match_offset;
    int                     mismatch_count;
    int                     offsets_pending;

    bit steady_run = 1'b0;
    bit draining   = 1'b0;
    int bytes_sent = 0;

    // pattern as last programmed, used to plant occurrences in the stream
    logic [7:0]  pat_bytes [PATTERN_BYTES];
    logic [31:0] pat_wild = '0;
    int          pat_span = 1;

    wildcard_byte_pattern_scan_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_offset  (match_offset)
    );

    scan_match_monitor match_tracker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_buffer   (end_of_buffer),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .match_offset    (match_offset),
        .mismatch_count  (mismatch_count),
        .offsets_pending (offsets_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk)
        out_stall <= (steady_run || draining) ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);

    // hard stop
    initial
    begin
        #(TIMEOUT_NS);
        $display("wildcard_byte_pattern_scan_unit verification failed");
        $finish;
    end

    // one register write per cycle, enable left high for the caller to drop
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0]  value);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(negedge clk);
    endtask

    // pattern bytes w*8 to w*8+7, little-endian
    function automatic logic [CFG_DATA_W-1:0] packed_word(input int w);
        logic [CFG_DATA_W-1:0] word;
        int                    k;
        for (k = 0; k < 8; k++)
            word[k*8 +: 8] = pat_bytes[w*8 + k];
        return word;
    endfunction

    // program all registers, words from pat_bytes, optionally poke spare indexes
    task automatic load_pattern(input logic [LEN_W-1:0] length, input logic [31:0] wild,
                                input bit stray);
        pat_wild = wild;
        pat_span = (length == 0) ? 1 : (length > PATTERN_BYTES) ? PATTERN_BYTES : length;
        put_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(length));
        put_reg(REG_PATTERN_LOW, packed_word(0));
        put_reg(REG_PATTERN_SECOND, packed_word(1));
        put_reg(REG_PATTERN_THIRD, packed_word(2));
        put_reg(REG_PATTERN_HIGH, packed_word(3));
        put_reg(REG_WILDCARD_MASK, CFG_DATA_W'(wild));
        if (stray)
        begin
            put_reg(REG_SPARE_LOW, '1);
            put_reg(REG_SPARE_HIGH, '1);
        end
        cfg_write_en <= 1'b0;
    endtask

    // one byte transaction with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] value, input bit last);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= value;
        end_of_buffer <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // hold the sender until every expected offset is back, then let the pipe empty
    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        while (offsets_pending != 0)
            @(negedge clk);
        if (settle > 0)
        begin
            draining <= 1'b1;
            repeat (settle) @(negedge clk);
            draining <= 1'b0;
        end
    endtask

    initial
    begin : stimulus
        int               phase;
        int               phase_bytes;
        int               phase_goal;
        int               buf_size;
        int               pos;
        int               k;
        int               cut;
        int               r;
        logic [LEN_W-1:0] reg_length;
        logic [31:0]      wild;
        logic [7:0]       b;
        logic [7:0]       fill_byte;
        bit               paused_once;

        for (k = 0; k < PATTERN_BYTES; k++)
            pat_bytes[k] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset pattern: one byte, 0x00
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b1);
        wait_for_results(SETTLE_CYCLES);

        // length zero acts as one, all wildcard bits set, position 0 still exact
        for (k = 0; k < PATTERN_BYTES; k++)
            pat_bytes[k] = 8'hFF;
        load_pattern(6'd0, 32'hFFFF_FFFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_for_results(SETTLE_CYCLES);

        // wildcard in the middle, then an occurrence cut by the buffer end
        for (k = 0; k < PATTERN_BYTES; k++)
            pat_bytes[k] = 8'h00;
        pat_bytes[0] = 8'h12;
        pat_bytes[1] = 8'h34;
        pat_bytes[2] = 8'h56;
        load_pattern(6'd3, 32'h0000_0002, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        wait_for_results(SETTLE_CYCLES);

        // zeros of a cleared window must not complete a match
        pat_bytes[0] = 8'h00;
        pat_bytes[1] = 8'h00;
        pat_bytes[2] = 8'hAA;
        load_pattern(6'd3, 32'h0000_0000, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_for_results(SETTLE_CYCLES);

        // oversized length saturates at the full window
        for (k = 0; k < PATTERN_BYTES; k++)
            pat_bytes[k] = 8'hFF;
        load_pattern(6'd63, 32'hFFFF_FFFE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_for_results(SETTLE_CYCLES);

        // random patterns, one setting per phase
        phase = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            // length, extremes in the first two phases
            r = $urandom_range(99);
            if (phase == 0)
                reg_length = 6'd32;
            else if (phase == 1)
                reg_length = 6'd63;
            else if (r < 45)
                reg_length = LEN_W'($urandom_range(1, 4));
            else if (r < 75)
                reg_length = LEN_W'($urandom_range(5, 12));
            else if (r < 90)
                reg_length = LEN_W'($urandom_range(13, 32));
            else if (r < 95)
                reg_length = 6'd0;
            else
                reg_length = LEN_W'($urandom_range(33, 63));

            // pattern bytes: all zero, all ones, one repeated byte or random
            r         = $urandom_range(9);
            fill_byte = 8'($urandom_range(255));
            for (k = 0; k < PATTERN_BYTES; k++)
            begin
                if (r == 0)
                    pat_bytes[k] = 8'h00;
                else if (r == 1)
                    pat_bytes[k] = 8'hFF;
                else if (r < 4)
                    pat_bytes[k] = fill_byte;
                else
                    pat_bytes[k] = 8'($urandom_range(255));
            end

            // wildcard mask
            r = $urandom_range(9);
            if (r < 3)
                wild = 32'h0000_0000;
            else if (r == 3)
                wild = 32'hFFFF_FFFF;
            else if (r < 7)
                wild = $urandom & $urandom;
            else
                wild = $urandom;

            load_pattern(reg_length, wild, $urandom_range(9) == 0);
            steady_run  <= (phase >= 3 && phase <= 5);
            phase_goal  = $urandom_range(40, 120);
            phase_bytes = 0;
            paused_once = (phase != 2) && ($urandom_range(3) != 0);

            while (phase_bytes < phase_goal)
            begin
                if ($urandom_range(99) < 15)
                    buf_size = $urandom_range(1, pat_span);
                else
                    buf_size = $urandom_range(1, 3 * pat_span + 8);
                pos = 0;
                while (pos < buf_size)
                begin
                    if ($urandom_range(99) < 55)
                    begin
                        // planted occurrence, sometimes damaged, cut at the buffer end
                        cut = ($urandom_range(99) < 15) ? $urandom_range(pat_span - 1) : -1;
                        for (k = 0; k < pat_span && pos < buf_size; k++)
                        begin
                            b = pat_bytes[k];
                            if (k != 0 && pat_wild[k])
                                b = 8'($urandom_range(255));
                            if (k == cut)
                                b = b ^ (8'h01 << $urandom_range(7));
                            push_byte(b, pos == buf_size - 1);
                            pos++;
                        end
                    end
                    else
                    begin
                        // noise, half of it taken from the pattern's own bytes
                        if ($urandom_range(1) == 0)
                            b = 8'($urandom_range(255));
                        else
                            b = pat_bytes[$urandom_range(pat_span - 1)];
                        push_byte(b, pos == buf_size - 1);
                        pos++;
                    end
                    // sender waits mid-buffer for every match so far
                    if (!paused_once && pos >= buf_size / 2)
                    begin
                        wait_for_results(0);
                        paused_once = 1'b1;
                    end
                end
                phase_bytes += buf_size;
            end
            wait_for_results(SETTLE_CYCLES);
            phase++;
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_scan_unit verification clean");
        else
            $display("wildcard_byte_pattern_scan_unit verification failed");
        $finish;
    end

endmodule
